// ===== hw/rtl/dedq_pkg.sv =====
// ----------------------------------------------------------------------------
// dedq_pkg
// Shared types and operation codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dedq_pkg;

	// operation codes carried by an input word
	localparam logic [2:0] OP_NONE      = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_REM_FRONT = 3'd3;
	localparam logic [2:0] OP_REM_BACK  = 3'd4;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;   // accept word, update pointers, write store
		logic load;   // capture result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;  // output register empty or being drained
	} sts_t;

endpackage

// ===== hw/rtl/dedq_ram.sv =====
// ----------------------------------------------------------------------------
// dedq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dedq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hw/rtl/dedq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dedq_ctrl
// Sequencer: accept a word, wait for the store read, hand off the result.
// ----------------------------------------------------------------------------
module dedq_ctrl
	import dedq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				// store read of new head/back is in flight
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dedq_dp.sv =====
// ----------------------------------------------------------------------------
// dedq_dp
// Datapath: head/tail pointers, count, item store and output register.
// ----------------------------------------------------------------------------
module dedq_dp
	import dedq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [OP_W-1:0]    operation,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] front_item,
	output logic [VALUE_W-1:0] back_item,
	output logic [COUNT_W-1:0] item_count,
	output logic               is_empty,
	output logic               is_full,
	output logic               rejected
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             rej_q;
	logic             out_valid_q;

	logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic             full, empty;
	logic             ins, rem;
	logic             we;
	logic [PTR_W-1:0] waddr;
	logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - 1'b1;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	assign ins = (operation == OP_INS_FRONT) || (operation == OP_INS_BACK);
	assign rem = (operation == OP_REM_FRONT) || (operation == OP_REM_BACK);

	assign we    = cmd.exec && ins && !full;
	assign waddr = (operation == OP_INS_FRONT) ? head_dec : tail_q;
	assign wdata = DATA_WIDTH'(value);

	dedq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (head_q),
		.raddr_b (tail_dec),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// pointer and count update on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rej_q   <= 1'b0;
		end else if (cmd.exec) begin
			rej_q <= (ins && full) || (rem && empty);
			unique case (operation)
				OP_INS_FRONT: begin
					if (!full) begin
						head_q  <= head_dec;
						count_q <= count_q + 1'b1;
					end
				end
				OP_INS_BACK: begin
					if (!full) begin
						tail_q  <= tail_inc;
						count_q <= count_q + 1'b1;
					end
				end
				OP_REM_FRONT: begin
					if (!empty) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				OP_REM_BACK: begin
					if (!empty) begin
						tail_q  <= tail_dec;
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			front_item <= empty ? '0 : VALUE_W'(rdata_a);
			back_item  <= empty ? '0 : VALUE_W'(rdata_b);
			item_count <= COUNT_W'(count_q);
			is_empty   <= empty;
			is_full    <= full;
			rejected   <= rej_q;
		end
	end

	assign out_valid = out_valid_q;

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count above capacity");

	// store is never written while full
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !full)
		else $error("write into full store");

	// accepted insert into non-full queue grows the count by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && ins && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not bump count");

	// a new result only appears after a load command
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("output valid without load");

endmodule

// ===== hw/rtl/bounded_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Bounded double-ended queue on a circular store, one result word per input.
// ----------------------------------------------------------------------------
// Each input word carries an operation (none, insert front, insert back,
// remove front, remove back) and a value; each one produces exactly one
// result word with the front and back items after the step (zero when
// empty), the item count, empty/full flags and a rejected flag for an
// insert into a full queue or a removal from an empty one. Unused operation
// codes act as none. The accept cycle updates the pointers and writes the
// store, and the next cycle reads the new front and back entries through
// the store's registered read ports before the result is loaded. The
// result sits in an output register, so the next word is accepted as soon
// as the previous result has moved into it, even if that result is still
// waiting downstream. No clearing pass after reset: only held entries are
// ever reported.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top
	import dedq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [VALUE_W-1:0] value,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] front_item,
	output logic [VALUE_W-1:0] back_item,
	output logic [COUNT_W-1:0] item_count,
	output logic               is_empty,
	output logic               is_full,
	output logic               rejected
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept -> read -> load
	dedq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pointers, store and output register
	dedq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.front_item (front_item),
		.back_item  (back_item),
		.item_count (item_count),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.rejected   (rejected)
	);

endmodule

// ===== dv/tb_bounded_double_ended_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_top
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A tracker object keeps its own copy of the circular store and pointers.
// Every accepted word updates it and queues the snapshot the block should
// report. Every accepted result is compared field by field against the
// oldest queued snapshot. Stimulus is a short directed pass (empty removals,
// spare codes, fill to full, inserts on a full queue) followed by random
// words in fill, drain and balanced phases so the queue keeps hitting both
// ends. The sender runs in bursts with gaps; the receiver stalls in modes of
// its own.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue_top;
	import dedq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int RANDOM_WORDS = 420;  // plus the directed pass, about 450 words
	localparam int IDLE_LIMIT   = 2000; // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 10;   // extra wait after the last result, to catch stray words
	localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

	typedef enum logic [1:0] {
		STALL_OFF,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_mode_t;

	// snapshot of the queue the block reports after one word
	typedef struct packed {
		logic [VALUE_W-1:0] front;
		logic [VALUE_W-1:0] back;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               full;
		logic               refused;
	} deque_view_t;

	// ------------------------------------------------------------------------
	// Tracker: mirrors the store and pointers, queues expected snapshots.
	// ------------------------------------------------------------------------
	class deque_tracker;
		logic [VALUE_W-1:0] slots[DEPTH];
		int head = 0;
		int tail = 0;  // one past the back item
		int held = 0;
		int mismatches = 0;
		deque_view_t pending_views[$];

		function void apply_word(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
			deque_view_t view;
			logic refused;
			refused = 1'b0;
			case (op)
				OP_INS_FRONT: begin
					if (held == DEPTH) refused = 1'b1;
					else begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						slots[head] = val;
						held++;
					end
				end
				OP_INS_BACK: begin
					if (held == DEPTH) refused = 1'b1;
					else begin
						slots[tail] = val;
						tail = (tail + 1) % DEPTH;
						held++;
					end
				end
				OP_REM_FRONT: begin
					if (held == 0) refused = 1'b1;
					else begin
						head = (head + 1) % DEPTH;
						held--;
					end
				end
				OP_REM_BACK: begin
					if (held == 0) refused = 1'b1;
					else begin
						tail = (tail == 0) ? DEPTH - 1 : tail - 1;
						held--;
					end
				end
				default: ;  // none and the spare codes leave the queue alone
			endcase
			view.front   = (held == 0) ? '0 : slots[head];
			view.back    = (held == 0) ? '0 : slots[(tail + DEPTH - 1) % DEPTH];
			view.count   = COUNT_W'(held);
			view.empty   = (held == 0);
			view.full    = (held == DEPTH);
			view.refused = refused;
			pending_views.push_back(view);
		endfunction

		function void compare_field(string name, logic [VALUE_W-1:0] want,
				logic [VALUE_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_view(deque_view_t got);
			deque_view_t want;
			if (pending_views.size() == 0) begin
				$error("result word with nothing outstanding");
				mismatches++;
				return;
			end
			want = pending_views.pop_front();
			compare_field("front_item", want.front, got.front);
			compare_field("back_item", want.back, got.back);
			compare_field("item_count", VALUE_W'(want.count), VALUE_W'(got.count));
			compare_field("is_empty", VALUE_W'(want.empty), VALUE_W'(got.empty));
			compare_field("is_full", VALUE_W'(want.full), VALUE_W'(got.full));
			compare_field("rejected", VALUE_W'(want.refused), VALUE_W'(got.refused));
		endfunction

		function int pending_count();
			return pending_views.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals; every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    operation = OP_NONE;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VALUE_W-1:0] front_item;
	logic [VALUE_W-1:0] back_item;
	logic [COUNT_W-1:0] item_count;
	logic               is_empty;
	logic               is_full;
	logic               rejected;

	deque_tracker tracker;
	int           burst_left;
	int           idle_cycles = 0;
	logic [7:0]   stall_phase = '0;
	stall_mode_t  stall_mode = STALL_OFF;

	bounded_double_ended_queue_top #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.front_item(front_item),
		.back_item (back_item),
		.item_count(item_count),
		.is_empty  (is_empty),
		.is_full   (is_full),
		.rejected  (rejected)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Receiver: stall mode is re-picked whenever the low six phase bits wrap.
	// Off gives long stretches with no back-pressure, periodic walks the stall
	// across every phase of the accept, read and load sequence.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		if (stall_phase[5:0] == '0)
			stall_mode <= stall_mode_t'($urandom_range(3));
		case (stall_mode)
			STALL_OFF:      out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(9) < 3);
			STALL_HEAVY:    out_stall <= ($urandom_range(9) < 7);
			STALL_PERIODIC: out_stall <= (stall_phase[2:0] < 3'd3);
			default:        out_stall <= 1'b0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Monitor and watchdog. Inputs are driven with nonblocking assignments,
	// so everything read here is the value the block saw at this edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.apply_word(operation, value);
			if (out_valid && !out_stall)
				tracker.check_view({front_item, back_item, item_count,
					is_empty, is_full, rejected});
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at the edge that took the word,
	// or, when a burst ends, drops the valid and returns after a random gap.
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
		int gap;
		in_valid  <= 1'b1;
		operation <= op;
		value     <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// fill phases push toward full, drain phases toward empty
	function automatic logic [OP_W-1:0] pick_operation(mix_mode_t mix);
		int r;
		int ins_f, ins_b, rem_f, rem_b, idle;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL:  begin ins_f = 40; ins_b = 75; rem_f = 85; rem_b = 93; idle = 97; end
			MIX_DRAIN: begin ins_f = 10; ins_b = 20; rem_f = 55; rem_b = 90; idle = 95; end
			default:   begin ins_f = 22; ins_b = 44; rem_f = 66; rem_b = 88; idle = 94; end
		endcase
		if (r < ins_f) return OP_INS_FRONT;
		if (r < ins_b) return OP_INS_BACK;
		if (r < rem_f) return OP_REM_FRONT;
		if (r < rem_b) return OP_REM_BACK;
		if (r < idle)  return OP_NONE;
		return OP_W'($urandom_range(OP_REM_BACK + 1, OP_LAST_CODE));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int                 ops_sent;
		int                 mix_left;
		mix_mode_t          mix;
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] val;

		ops_sent = 0;
		mix_left = 0;
		mix = MIX_EVEN;
		tracker = new();
		burst_left = $urandom_range(0, 12);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// removals on an empty queue are refused
		send_word(OP_REM_FRONT, 32'h1234_5678);
		send_word(OP_REM_BACK, 32'hFFFF_FFFF);
		send_word(OP_NONE, 32'hFFFF_FFFF);
		// spare codes behave like none
		for (int c = OP_REM_BACK + 1; c <= OP_LAST_CODE; c++)
			send_word(OP_W'(c), 32'hA5A5_A5A5);
		// single item at each end, then back to empty from each end
		send_word(OP_INS_FRONT, '0);
		send_word(OP_INS_BACK, '1);
		send_word(OP_REM_FRONT, '1);
		send_word(OP_REM_BACK, '0);
		// fill to full from both ends with extreme and one-hot values
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0:       val = '0;
				1:       val = '1;
				default: val = VALUE_W'(1) << (i * 2);
			endcase
			send_word(i[0] ? OP_INS_FRONT : OP_INS_BACK, val);
		end
		// inserts on a full queue are dropped
		send_word(OP_INS_FRONT, 32'hDEAD_BEEF);
		send_word(OP_INS_BACK, 32'hCAFE_F00D);

		// random phases; every word counts toward the total
		while (ops_sent < RANDOM_WORDS) begin
			if (mix_left == 0) begin
				mix = mix_mode_t'($urandom_range(2));
				mix_left = $urandom_range(20, 60);
			end
			mix_left--;
			op = pick_operation(mix);
			val = pick_value();
			send_word(op, val);
			ops_sent++;
		end
		if (in_valid) in_valid <= 1'b0;

		// let every outstanding result come out, then watch for strays
		while (tracker.pending_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending_count() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dedq_pkg.sv
hw/rtl/dedq_ram.sv
hw/rtl/dedq_ctrl.sv
hw/rtl/dedq_dp.sv
hw/rtl/bounded_double_ended_queue_top.sv
dv/tb_bounded_double_ended_queue_top.sv
